/* rtl/core/gwm_pkg.sv */
// shared types and constants of the glob wildcard matcher
package gwm_pkg;

  localparam int PAT_MAX_DEF = 32;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [7:0] STAR_CODE = 8'd42;
  localparam logic [7:0] ANY_CODE  = 8'd63;

  typedef enum logic [1:0] {
    FUNC_LOAD    = 2'd0,
    FUNC_NAME    = 2'd1,
    FUNC_EMPTY_Q = 2'd2,
    FUNC_CLEAR   = 2'd3
  } func_e;

  typedef struct packed {
    func_e      op;
    logic [7:0] char_value;
    logic       last;
    logic       has_result;
  } entry_t;

endpackage

/* rtl/core/glob_wildcard_matcher_top.sv */
// top level of the glob wildcard matcher
//
// usage:
//   slave side takes one transaction per item: tuser holds the function
//   (load pattern byte, name byte, empty name query, set empty pattern),
//   tdata the pattern or name byte, tlast the final byte of a pattern or name.
//   load a pattern byte by byte, then stream name bytes; '*' matches any run,
//   '?' any one byte, pattern bytes beyond PAT_MAX are dropped.
//   master side gives one transaction with the match bit for every final
//   name byte and every empty name query; other items give nothing.
// a result item is written into the queue when accepted, then the back end
//   steps its match bit into the output register, where it becomes valid.
// throughput: one item per cycle unless the output stalls; the whole position
//   set moves one step per name byte, via position compare and star closure.
// reset: pattern is empty, no name in progress, queue and output are empty.
// stall: the output register holds its result; items without a result still
//   drain, a result item waits in the queue, and s_tready falls once the
//   queue is full.
module glob_wildcard_matcher_top #(
  parameter int PAT_MAX = gwm_pkg::PAT_MAX_DEF,
  parameter int QDEPTH  = gwm_pkg::QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] char_value
  input  logic       s_tlast,
  input  logic [1:0] s_tuser,   // [1:0] func
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata    // [0] matched, [7:1] zero
);

  // classified transaction on its way into the queue
  logic            push_valid;
  logic            push_ready;
  gwm_pkg::entry_t push_entry;

  // head of the queue toward the back end
  logic            q_valid;
  logic            q_pop;
  gwm_pkg::entry_t q_entry;

  gwm_front u_front (
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tlast    (s_tlast),
    .s_tuser    (s_tuser),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_entry (push_entry)
  );

  // decouples acceptance from execution so either side can stall alone
  gwm_queue #(
    .DEPTH (QDEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_entry (push_entry),
    .pop_valid  (q_valid),
    .pop        (q_pop),
    .pop_entry  (q_entry)
  );

  // pattern store, position set and output register
  gwm_back #(
    .PAT_MAX (PAT_MAX)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_entry  (q_entry),
    .q_pop    (q_pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule

/* rtl/core/gwm_front.sv */
// front end: accepts input transactions and classifies them into queue entries
module gwm_front (
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [7:0]       s_tdata,
  input  logic             s_tlast,
  input  logic [1:0]       s_tuser,
  output logic             push_valid,
  input  logic             push_ready,
  output gwm_pkg::entry_t  push_entry
);

  gwm_pkg::func_e op;

  always_comb begin
    op = gwm_pkg::func_e'(s_tuser);
    push_entry.op         = op;
    push_entry.char_value = s_tdata;
    push_entry.last       = s_tlast;
    // only a final name byte or an empty name query gives a result
    case (op)
      gwm_pkg::FUNC_NAME:    push_entry.has_result = s_tlast;
      gwm_pkg::FUNC_EMPTY_Q: push_entry.has_result = 1'b1;
      default:               push_entry.has_result = 1'b0;
    endcase
  end

  assign push_valid = s_tvalid;
  assign s_tready   = push_ready;

endmodule

/* rtl/core/gwm_queue.sv */
// short queue between front and back end
module gwm_queue #(
  parameter int DEPTH = gwm_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push_valid,
  output logic             push_ready,
  input  gwm_pkg::entry_t  push_entry,
  output logic             pop_valid,
  input  logic             pop,
  output gwm_pkg::entry_t  pop_entry
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  gwm_pkg::entry_t  entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign push_ready = (count != CNT_W'(DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_entry  = entries[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

/* rtl/core/gwm_back.sv */
// back end: pattern store, reachable position set and result register
module gwm_back #(
  parameter int PAT_MAX = gwm_pkg::PAT_MAX_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_valid,
  input  gwm_pkg::entry_t  q_entry,
  output logic             q_pop,
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [7:0]       m_tdata
);

  localparam int VW    = PAT_MAX + 1;
  localparam int LEN_W = $clog2(VW);

  logic [7:0]         pat_bytes [PAT_MAX];
  logic [LEN_W-1:0]   pat_len, pat_len_next;
  logic               loading, loading_next;
  logic [VW-1:0]      reach, reach_next;
  logic               in_prog, in_prog_next;
  logic               out_valid;
  logic               out_matched;

  logic [PAT_MAX-1:0] star_mask;
  logic [PAT_MAX-1:0] pass_mask;
  logic [VW-1:0]      prop;
  logic [VW-1:0]      start_vec;
  logic [VW-1:0]      base;
  logic [VW-1:0]      adv_raw;
  logic [VW-1:0]      stepped;
  logic [LEN_W-1:0]   wr_idx;
  logic               wr_en;
  logic               res_bit;

  // star closure as a prefix network: a set bit runs forward across stars
  function automatic logic [VW-1:0] close_fn(input logic [VW-1:0] set_in,
                                             input logic [VW-1:0] prop_in);
    logic [VW-1:0] g;
    logic [VW-1:0] pr;
    logic [VW-1:0] g_n;
    logic [VW-1:0] pr_n;
    g  = set_in;
    pr = prop_in;
    for (int s = 0; s < LEN_W; s++) begin
      g_n  = g;
      pr_n = pr;
      for (int p = 0; p < VW; p++) begin
        if (p >= (1 << s)) begin
          g_n[p]  = g[p] | (pr[p] & g[p - (1 << s)]);
          pr_n[p] = pr[p] & pr[p - (1 << s)];
        end
      end
      g  = g_n;
      pr = pr_n;
    end
    return g;
  endfunction

  always_comb begin
    for (int p = 0; p < PAT_MAX; p++) begin
      star_mask[p] = (LEN_W'(p) < pat_len) && (pat_bytes[p] == gwm_pkg::STAR_CODE);
      pass_mask[p] = (LEN_W'(p) < pat_len) && (pat_bytes[p] != gwm_pkg::STAR_CODE) &&
                     ((pat_bytes[p] == gwm_pkg::ANY_CODE) ||
                      (pat_bytes[p] == q_entry.char_value));
    end
  end

  assign prop      = {star_mask, 1'b0};
  assign start_vec = close_fn(VW'(1), prop);
  assign base      = in_prog ? reach : start_vec;
  // a star keeps its position, a matching byte moves one position on
  assign adv_raw   = {base[PAT_MAX-1:0] & pass_mask, 1'b0} |
                     {1'b0, base[PAT_MAX-1:0] & star_mask};
  assign stepped   = close_fn(adv_raw, prop);

  assign q_pop  = q_valid && (!q_entry.has_result || !out_valid || m_tready);
  assign wr_idx = loading ? pat_len : '0;
  assign wr_en  = q_pop && (q_entry.op == gwm_pkg::FUNC_LOAD) &&
                  (wr_idx < LEN_W'(PAT_MAX));

  always_comb begin
    pat_len_next = pat_len;
    loading_next = loading;
    reach_next   = reach;
    in_prog_next = in_prog;
    res_bit      = 1'b0;
    case (q_entry.op)
      gwm_pkg::FUNC_LOAD: begin
        in_prog_next = 1'b0;
        pat_len_next = (wr_idx < LEN_W'(PAT_MAX)) ? wr_idx + 1'b1 : wr_idx;
        loading_next = !q_entry.last;
      end
      gwm_pkg::FUNC_NAME: begin
        loading_next = 1'b0;
        reach_next   = stepped;
        in_prog_next = !q_entry.last;
        res_bit      = stepped[pat_len];
      end
      gwm_pkg::FUNC_EMPTY_Q: begin
        loading_next = 1'b0;
        in_prog_next = 1'b0;
        res_bit      = start_vec[pat_len];
      end
      default: begin
        pat_len_next = '0;
        loading_next = 1'b0;
        in_prog_next = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    for (int p = 0; p < PAT_MAX; p++) begin
      if (wr_en && (wr_idx == LEN_W'(p))) begin
        pat_bytes[p] <= q_entry.char_value;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pat_len   <= '0;
      loading   <= 1'b0;
      reach     <= '0;
      in_prog   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (q_pop) begin
        pat_len <= pat_len_next;
        loading <= loading_next;
        reach   <= reach_next;
        in_prog <= in_prog_next;
      end
      if (q_pop && q_entry.has_result) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && q_entry.has_result) begin
      out_matched <= res_bit;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {7'b0, out_matched};

endmodule

/* rtl/core/gwm_checker.sv */
// port level checks of the glob wildcard matcher, bound to the top level
module gwm_checker (
  input logic       clk,
  input logic       rst,
  input logic       s_tready,
  input logic       m_tvalid,
  input logic       m_tready,
  input logic [7:0] m_tdata
);

  // a stalled result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // reset empties the output register
  a_rst_out: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

  // reset empties the queue, so input is taken right away
  a_rst_ready: assert property (@(posedge clk) $past(rst) |-> s_tready)
    else $error("input not ready after reset");

  // only the match bit is ever set
  a_pad_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[7:1] == 7'd0))
    else $error("padding bits set in result");

endmodule

bind glob_wildcard_matcher_top gwm_checker u_gwm_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

/* tb/testbench.sv */
// self-checking testbench for the glob wildcard matcher: random patterns and names vs a predictor
`timescale 1ns / 100ps

module testbench;

  localparam int PAT_MAX     = gwm_pkg::PAT_MAX_DEF;
  localparam int ITEM_TARGET = 1850;

  typedef struct {
    gwm_pkg::func_e op;
    logic [7:0]     ch;
    logic           is_last;
    int unsigned    gap;          // idle cycles before this transaction is offered
    bit             drain_first;  // hold off until every pending match bit has come back
  } stim_item_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       s_tvalid = 1'b0;
  logic       s_tready;
  logic [7:0] s_tdata = '0;   // [7:0] char_value
  logic       s_tlast = 1'b0;
  logic [1:0] s_tuser = '0;   // [1:0] func
  logic       m_tvalid;
  logic       m_tready = 1'b0;
  logic [7:0] m_tdata;        // [0] matched, [7:1] zero

  glob_wildcard_matcher_top uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always #5 clk = ~clk;

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
  end

  // stimulus and expectations
  stim_item_t  stim_q[$];
  logic        match_due[$];
  int unsigned errors = 0;
  bit          fast_burst = 1'b0;
  bit          drain_next = 1'b0;

  // predictor state
  logic [7:0]       pat_store [PAT_MAX];
  int unsigned      pat_len = 0;
  bit               pat_loading = 1'b0;
  logic [PAT_MAX:0] live_pos = '0;
  bit               name_open = 1'b0;

  function automatic logic [PAT_MAX:0] star_closure(logic [PAT_MAX:0] set);
    for (int p = 0; p < PAT_MAX; p++)
      if (p < pat_len && set[p] && pat_store[p] == gwm_pkg::STAR_CODE) set[p+1] = 1'b1;
    return set;
  endfunction

  function automatic logic [PAT_MAX:0] advance_positions(logic [PAT_MAX:0] set,
                                                         logic [7:0] ch);
    logic [PAT_MAX:0] nxt;
    nxt = '0;
    for (int p = 0; p < PAT_MAX; p++) begin
      if (p < pat_len && set[p]) begin
        if (pat_store[p] == gwm_pkg::STAR_CODE) nxt[p] = 1'b1;
        else if (pat_store[p] == gwm_pkg::ANY_CODE || pat_store[p] == ch) nxt[p+1] = 1'b1;
      end
    end
    return star_closure(nxt);
  endfunction

  task automatic track_glob_item(stim_item_t it);
    logic [PAT_MAX:0] empty_set;
    case (it.op)
      gwm_pkg::FUNC_LOAD: begin
        name_open = 1'b0;
        live_pos  = '0;
        if (!pat_loading) begin
          pat_len     = 0;
          pat_loading = 1'b1;
        end
        // bytes past capacity are dropped
        if (pat_len < PAT_MAX) begin
          pat_store[pat_len] = it.ch;
          pat_len++;
        end
        if (it.is_last) pat_loading = 1'b0;
      end
      gwm_pkg::FUNC_NAME: begin
        pat_loading = 1'b0;
        if (!name_open) live_pos = star_closure({{PAT_MAX{1'b0}}, 1'b1});
        live_pos = advance_positions(live_pos, it.ch);
        if (it.is_last) begin
          name_open = 1'b0;
          match_due.push_back(live_pos[pat_len]);
          live_pos = '0;
        end else begin
          name_open = 1'b1;
        end
      end
      gwm_pkg::FUNC_EMPTY_Q: begin
        pat_loading = 1'b0;
        name_open   = 1'b0;
        empty_set   = star_closure({{PAT_MAX{1'b0}}, 1'b1});
        match_due.push_back(empty_set[pat_len]);
        live_pos = '0;
      end
      default: begin
        pat_len     = 0;
        pat_loading = 1'b0;
        name_open   = 1'b0;
        live_pos    = '0;
      end
    endcase
  endtask

  task automatic push_item(gwm_pkg::func_e op, logic [7:0] ch, logic is_last);
    stim_item_t it;
    it.op          = op;
    it.ch          = ch;
    it.is_last     = is_last;
    it.gap         = fast_burst ? 0 : $urandom_range(0, 9);
    it.drain_first = drain_next;
    drain_next     = 1'b0;
    stim_q.push_back(it);
  endtask

  function automatic logic [7:0] pick_pattern_char();
    case ($urandom_range(0, 9))
      0, 1, 2: return "a";
      3:       return "b";
      4, 5:    return gwm_pkg::STAR_CODE;
      6, 7:    return gwm_pkg::ANY_CODE;
      8:       return "c";
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [7:0] pick_name_char();
    case ($urandom_range(0, 9))
      0, 1, 2: return "a";
      3, 4:    return "b";
      5:       return gwm_pkg::STAR_CODE;
      6:       return gwm_pkg::ANY_CODE;
      7:       return 8'h00;
      8:       return 8'hff;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // driver: offers queued transactions after their idle gap
  int unsigned idle_cnt = 0;
  stim_item_t  cur_item;

  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      idle_cnt = 0;
    end else begin
      if (s_tvalid && s_tready) track_glob_item(cur_item);
      if (!s_tvalid || s_tready) begin
        if (stim_q.size() == 0) begin
          s_tvalid <= 1'b0;
        end else if (idle_cnt < stim_q[0].gap) begin
          idle_cnt++;
          s_tvalid <= 1'b0;
        end else if (stim_q[0].drain_first && match_due.size() != 0) begin
          s_tvalid <= 1'b0;
        end else begin
          cur_item = stim_q.pop_front();
          idle_cnt = 0;
          s_tvalid <= 1'b1;
          s_tdata  <= cur_item.ch;
          s_tlast  <= cur_item.is_last;
          s_tuser  <= cur_item.op;
        end
      end
    end
  end

  // monitor: random backpressure, compares each match bit with the oldest expectation
  int unsigned stall_cnt = 0;
  bit          sink_calm = 1'b0;

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      stall_cnt = 0;
    end else begin
      if (m_tvalid === 1'b1 && m_tready) begin
        if (match_due.size() == 0) begin
          $display("%0t unexpected result: expected none, got %h", $time, m_tdata);
          errors++;
        end else if (m_tdata !== {7'b0, match_due[0]}) begin
          $display("%0t mismatch on matched: expected %h, got %h",
                   $time, {7'b0, match_due[0]}, m_tdata);
          errors++;
          void'(match_due.pop_front());
        end else begin
          void'(match_due.pop_front());
        end
        if ($urandom_range(0, 24) == 0) sink_calm = !sink_calm;
        stall_cnt = sink_calm ? 0 : $urandom_range(0, 9);
      end else if (stall_cnt > 0) begin
        stall_cnt--;
      end
      m_tready <= (stall_cnt == 0);
    end
  end

  initial begin : stimulus
    logic [7:0]  pattern[$];
    logic [7:0]  name[$];
    int unsigned plen;
    int unsigned pos;
    bit          open_end;

    // directed: empty pattern, lone star, zero and 0xff bytes, broken sequences
    push_item(gwm_pkg::FUNC_CLEAR,   8'h00, 1'b1);
    push_item(gwm_pkg::FUNC_EMPTY_Q, 8'hff, 1'b0);   // empty pattern matches empty name
    push_item(gwm_pkg::FUNC_NAME,    "x",   1'b1);   // but no other name
    push_item(gwm_pkg::FUNC_LOAD,    gwm_pkg::STAR_CODE, 1'b1);
    push_item(gwm_pkg::FUNC_EMPTY_Q, 8'h00, 1'b1);
    push_item(gwm_pkg::FUNC_NAME,    8'hff, 1'b1);
    push_item(gwm_pkg::FUNC_LOAD,    8'h00, 1'b0);
    push_item(gwm_pkg::FUNC_LOAD,    gwm_pkg::ANY_CODE, 1'b0);
    push_item(gwm_pkg::FUNC_LOAD,    8'hff, 1'b1);
    push_item(gwm_pkg::FUNC_NAME,    8'h00, 1'b0);
    push_item(gwm_pkg::FUNC_NAME,    gwm_pkg::STAR_CODE, 1'b0);
    push_item(gwm_pkg::FUNC_NAME,    8'hff, 1'b1);
    push_item(gwm_pkg::FUNC_NAME,    "a",   1'b0);   // name dropped by the next load
    push_item(gwm_pkg::FUNC_LOAD,    "b",   1'b1);
    push_item(gwm_pkg::FUNC_LOAD,    "c",   1'b0);   // load closed by the name byte
    push_item(gwm_pkg::FUNC_NAME,    "c",   1'b1);
    push_item(gwm_pkg::FUNC_EMPTY_Q, 8'h00, 1'b0);
    push_item(gwm_pkg::FUNC_LOAD,    "d",   1'b0);
    push_item(gwm_pkg::FUNC_CLEAR,   8'hff, 1'b0);   // clear during a load
    push_item(gwm_pkg::FUNC_EMPTY_Q, 8'h00, 1'b1);
    drain_next = 1'b1;

    while (stim_q.size() < ITEM_TARGET) begin
      if ($urandom_range(0, 11) == 0) fast_burst = !fast_burst;
      if ($urandom_range(0, 149) == 0) drain_next = 1'b1;

      // noise
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 4))
          push_item(gwm_pkg::func_e'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                    1'($urandom_range(0, 1)));
        continue;
      end

      plen     = ($urandom_range(0, 14) == 0) ? $urandom_range(30, 40) : $urandom_range(0, 6);
      open_end = ($urandom_range(0, 9) == 0);
      pattern.delete();
      repeat (plen) pattern.push_back(pick_pattern_char());
      if (plen == 0)
        push_item(gwm_pkg::FUNC_CLEAR, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      else
        foreach (pattern[i])
          push_item(gwm_pkg::FUNC_LOAD, pattern[i], i == plen - 1 && !open_end);

      repeat ($urandom_range(1, 4)) begin
        name.delete();
        if ($urandom_range(0, 5) == 0) begin
          repeat ($urandom_range(0, 5)) name.push_back(pick_name_char());
        end else begin
          // name built to follow the pattern, then perhaps damaged
          for (int i = 0; i < plen && i < PAT_MAX; i++) begin
            if (pattern[i] == gwm_pkg::STAR_CODE)
              repeat ($urandom_range(0, 2)) name.push_back(pick_name_char());
            else if (pattern[i] == gwm_pkg::ANY_CODE)
              name.push_back(pick_name_char());
            else
              name.push_back(pattern[i]);
          end
          if ($urandom_range(0, 3) == 0 && name.size() != 0) begin
            pos = $urandom_range(0, name.size() - 1);
            case ($urandom_range(0, 2))
              0:       name[pos] = pick_name_char();
              1:       name.delete(pos);
              default: name.insert(pos, pick_name_char());
            endcase
          end
        end
        if (name.size() == 0)
          push_item(gwm_pkg::FUNC_EMPTY_Q, 8'($urandom_range(0, 255)),
                    1'($urandom_range(0, 1)));
        else
          foreach (name[i]) push_item(gwm_pkg::FUNC_NAME, name[i], i == name.size() - 1);
      end
    end

    wait (!rst);
    while (stim_q.size() != 0 || s_tvalid || match_due.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    while (match_due.size() != 0) begin
      $display("%0t missing result: expected %h, got none", $time, {7'b0, match_due[0]});
      void'(match_due.pop_front());
      errors++;
    end
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
